// ===== sv/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned PriW  = 8;
  localparam int unsigned IdW   = 16;
  localparam int unsigned FillW = 5;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One inbound transaction.
  typedef struct packed {
    action_e          action;
    logic [PriW-1:0]  item_priority;
    logic [IdW-1:0]   item_id;
  } req_t;

  // One outbound transaction.
  typedef struct packed {
    status_e          status;
    logic             out_valid;
    logic [IdW-1:0]   out_id;
    logic [PriW-1:0]  out_priority;
    logic [FillW-1:0] fill_level;
  } rsp_t;

  // One stored entry.
  typedef struct packed {
    logic [PriW-1:0] pri;
    logic [IdW-1:0]  id;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,      // slot holds a live entry
  input  logic                ins_left_i, // new item lands at or before left slot
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  output logic                ins_o,
  output spq_pkg::entry_t     entry_o
);
  import spq_pkg::*;

  entry_t ent_q, ent_d;

  // Strictly greater priority keeps equal priorities in arrival order.
  assign ins_o   = !occ_i || (ent_q.pri > ctrl_i.item.pri);
  assign entry_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.push) begin
      if (ins_left_i) begin
        ent_d = left_i;
      end else if (ins_o) begin
        ent_d = ctrl_i.item;
      end
    end else if (ctrl_i.pop) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain, fill count and result register.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (req_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (rsp_t)
//
// One transaction a cycle unless in_stall_o is raised: a push or pop is applied to
// the whole chain in the cycle it is accepted, and its result appears in the
// output register on the next edge. The figure is set by the single compare in each cell.
// Reset clears the fill count and the output valid; cell contents are left as
// they are and are never read until written.
// in_stall_o is raised only while a result sits in the output register and
// the downstream side stalls it.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::rsp_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_vld_q;
  rsp_t            rsp_q, rsp_d;

  logic            accept;
  logic            is_full, is_empty;
  logic            push_ok, pop_ok;
  cell_ctrl_t      ctrl;

  entry_t          ent    [DEPTH];
  logic            ins    [DEPTH];
  logic            occ    [DEPTH];

  // Result register parts the two sides; a waiting result blocks only when stalled.
  assign in_stall_o = out_vld_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign push_ok  = accept && (in_data_i.action == ACT_PUSH) && !is_full;
  assign pop_ok   = accept && (in_data_i.action == ACT_POP) && !is_empty;

  assign ctrl.push     = push_ok;
  assign ctrl.pop      = pop_ok;
  assign ctrl.item.pri = in_data_i.item_priority;
  assign ctrl.item.id  = in_data_i.item_id;

  // Chain of cells; slot 0 is the head of the queue.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign occ[g] = (CntW'(g) < count_q);
    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[g]),
      .ins_left_i ((g == 0) ? 1'b0 : ins[(g == 0) ? 0 : g - 1]),
      .left_i     (ent[(g == 0) ? 0 : g - 1]),
      .right_i    (ent[(g == DEPTH - 1) ? g : g + 1]),
      .ins_o      (ins[g]),
      .entry_o    (ent[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (push_ok) begin
      count_d = count_q + CntW'(1);
    end else if (pop_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Result of the accepted transaction.
  always_comb begin
    rsp_d              = '0;
    rsp_d.status       = ST_DONE;
    rsp_d.fill_level   = FillW'(count_d);
    if (in_data_i.action == ACT_PUSH) begin
      if (is_full) begin
        rsp_d.status = ST_FULL;
      end
    end else if (is_empty) begin
      rsp_d.status = ST_EMPTY;
    end else begin
      rsp_d.out_valid    = 1'b1;
      rsp_d.out_id       = ent[0].id;
      rsp_d.out_priority = ent[0].pri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = rsp_q;

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted priority queue: push/pop traffic checked against a queue model.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned NumItems   = 1400;
  // Cycles without any transaction on either side before the run is abandoned.
  // Worst legitimate quiet spell is the long receiver hold plus a sender gap.
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned DrainAt    = 700;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  sorted_priority_queue #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Requests waiting to be offered, results owed by the block, and the
  // queue contents as the block should hold them (front = next to leave).
  req_t   pending_req_q[$];
  rsp_t   owed_rsp_q[$];
  entry_t sorted_entries_q[$];

  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the queue model and returns the result it owes.
  // A push lands after every entry of equal or lower priority value, so ties
  // leave in arrival order.
  function automatic rsp_t apply_queue_op(req_t req);
    rsp_t        r;
    entry_t      e;
    int unsigned pos;
    r = '0;
    r.status = ST_DONE;
    if (req.action == ACT_PUSH) begin
      if (sorted_entries_q.size() >= Depth) begin
        r.status = ST_FULL;
      end else begin
        pos = sorted_entries_q.size();
        for (int i = 0; i < sorted_entries_q.size(); i++) begin
          if (sorted_entries_q[i].pri > req.item_priority) begin
            pos = i;
            break;
          end
        end
        e.pri = req.item_priority;
        e.id  = req.item_id;
        sorted_entries_q.insert(pos, e);
      end
    end else if (sorted_entries_q.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e = sorted_entries_q.pop_front();
      r.out_valid    = 1'b1;
      r.out_id       = e.id;
      r.out_priority = e.pri;
    end
    r.fill_level = FillW'(sorted_entries_q.size());
    return r;
  endfunction

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  function automatic void add_req(action_e act, int unsigned pri, int unsigned id);
    req_t r;
    r.action        = act;
    r.item_priority = PriW'(pri);
    r.item_id       = IdW'(id);
    pending_req_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending requests in bursts with random gaps. Prediction is
  // made here, at the edge where the inbound transaction is accepted.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;
  bit          drain_pause;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      in_data     <= '0;
      burst_left  = 0;
      gap_left    = 0;
      drain_pause = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_rsp_q.push_back(apply_queue_op(in_data));
        n_accepted++;
        // once, stop feeding until the block has handed back everything
        if (n_accepted == DrainAt) drain_pause = 1'b1;
      end
      if (drain_pause && owed_rsp_q.size() == 0) drain_pause = 1'b0;
      // a stalled transaction is held as it is
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (drain_pause || pending_req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_req_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            // a third of bursts run straight on into the next one
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each outbound transaction and drives the receiver stall.
  // Stall behaviour changes in phases; twice a long hold leaves a result waiting in
  // the output register so that the block pushes back on the sender.
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode;
  int unsigned phase_left;
  int unsigned hold_left;
  int unsigned holds_done;

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_mode = STALL_NONE;
      phase_left = 0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          n_errors++;
        end else begin
          want = owed_rsp_q.pop_front();
          cmp_field("status", want.status, out_data.status);
          cmp_field("out_valid", want.out_valid, out_data.out_valid);
          cmp_field("out_id", want.out_id, out_data.out_id);
          cmp_field("out_priority", want.out_priority, out_data.out_priority);
          cmp_field("fill_level", want.fill_level, out_data.fill_level);
        end
      end

      if (hold_left == 0 && ((holds_done == 0 && n_accepted >= 300) ||
                             (holds_done == 1 && n_accepted >= 1100))) begin
        hold_left = HoldCycles;
        holds_done++;
      end

      if (phase_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 120);
      end else begin
        phase_left--;
      end

      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Watchdog: gives up after a long spell with no transaction either side.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned push_pct;
    int unsigned base_pri;
    int unsigned pri;
    int unsigned n_total;
    bit          narrow;
    action_e     act;

    // pop on empty, with every payload bit set to show it is ignored
    add_req(ACT_POP, 8'hff, 16'hffff);
    // priority and id extremes, plus ties that must leave in arrival order
    add_req(ACT_PUSH, 8'hff, 16'hffff);
    add_req(ACT_PUSH, 8'h00, 16'h0000);
    add_req(ACT_PUSH, 8'h80, 16'h1234);
    add_req(ACT_PUSH, 8'h80, 16'h5678);
    add_req(ACT_PUSH, 8'h00, 16'haaaa);
    repeat (5) add_req(ACT_POP, 8'h00, 16'h0000);
    add_req(ACT_POP, 8'h55, 16'h5555);
    // fill to the brim in descending order (every push lands at the front),
    // then a push that must be refused
    for (int i = 0; i < Depth; i++) add_req(ACT_PUSH, Depth - 1 - i, 16'hc000 + i);
    add_req(ACT_PUSH, 8'h00, 16'hbeef);

    // Random part in segments: each has its own push/pop mix, so the queue
    // swings between full and empty. Narrow segments crowd priorities
    // together to give plenty of ties.
    while (pending_req_q.size() < NumItems) begin
      case ($urandom_range(0, 4))
        0:       push_pct = 90;
        1:       push_pct = 65;
        2:       push_pct = 50;
        3:       push_pct = 35;
        default: push_pct = 10;
      endcase
      narrow   = $urandom_range(0, 1);
      base_pri = $urandom_range(0, 252);
      repeat ($urandom_range(8, 48)) begin
        act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
        case ($urandom_range(0, 15))
          0:       pri = 0;
          1:       pri = 255;
          default: pri = narrow ? base_pri + $urandom_range(0, 3) : $urandom_range(0, 255);
        endcase
        add_req(act, pri, $urandom_range(0, 16'hffff));
      end
    end
    n_total = pending_req_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every request accepted (and so predicted), then every result returned
    while (n_accepted < n_total) @(posedge clk_i);
    while (owed_rsp_q.size() != 0) @(posedge clk_i);
    // one-deep result register: waiting on after the drain catches any stray result
    repeat (10) @(posedge clk_i);

    if (n_errors == 0 && owed_rsp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
